### sv/tbbv_pkg.sv
// shared types and constants for the terrain blend brush vertex unit
package tbbv_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FIELD_W        = 32;
  localparam int WEIGHT_W       = 8;
  localparam int RAD_W          = 24;
  localparam int STR_W          = 8;
  localparam int LAYER_W        = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 24;

  localparam int PRE_STEPS = 6;
  localparam int SQ_STEPS  = RAD_W + STR_W;
  localparam int DIV_STEPS = WEIGHT_W;
  localparam int LATENCY   = PRE_STEPS + SQ_STEPS + 1 + DIV_STEPS + 2 + DIV_STEPS;

  localparam logic [RAD_W-1:0]    RADIUS_RST   = RAD_W'(256);
  localparam logic [STR_W-1:0]    STRENGTH_RST = STR_W'(255);
  localparam logic [WEIGHT_W-1:0] W_MAX        = WEIGHT_W'(255);

  localparam logic [LAYER_W-1:0] LAYER_ALPHA = 3'b111;
  localparam logic [LAYER_W-1:0] LAYER_0     = 3'b000;
  localparam logic [LAYER_W-1:0] LAYER_1     = 3'b001;
  localparam logic [LAYER_W-1:0] LAYER_2     = 3'b010;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS   = 2'd0,
    CFG_STRENGTH = 2'd1,
    CFG_LAYER    = 2'd2,
    CFG_ERASE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] centre_x;
    logic signed [FIELD_W-1:0] centre_y;
    logic signed [FIELD_W-1:0] centre_z;
    logic signed [FIELD_W-1:0] vertex_x;
    logic signed [FIELD_W-1:0] vertex_y;
    logic signed [FIELD_W-1:0] vertex_z;
    logic [WEIGHT_W-1:0]       weight_in_0;
    logic [WEIGHT_W-1:0]       weight_in_1;
    logic [WEIGHT_W-1:0]       weight_in_2;
  } in_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_out_0;
    logic [WEIGHT_W-1:0] weight_out_1;
    logic [WEIGHT_W-1:0] weight_out_2;
    logic                touched;
  } out_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] w0;
    logic [WEIGHT_W-1:0] w1;
    logic [WEIGHT_W-1:0] w2;
  } pay_t;

endpackage

### sv/terrain_blend_brush_vertex_unit.sv
// terrain blend brush vertex unit: pipelined splat weight brush for one vertex per clock
//
//  channel | ports                              | transfer
//  --------+------------------------------------+------------------------------
//  input   | start, busy, in_data               | start high while busy low
//  result  | out_strobe, out_data               | one cycle per strobe
//  config  | cfg_valid, cfg_ready, cfg_index,   | valid and ready both high
//          | cfg_data                           |
//
// one vertex enters every clock; busy stays low
// the result is formed by the 32 step square root and the two 8 step dividers
// synchronous active low reset clears all valid bits and loads the configuration registers
// the result side has no backpressure, so nothing in the pipeline stalls
module terrain_blend_brush_vertex_unit import tbbv_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_data,
  output logic                  out_strobe,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW   = COORD_BITS;
  localparam int AW   = (CW > RAD_W) ? CW : RAD_W;
  localparam int SQW  = 2 * RAD_W;
  localparam int D2W  = SQW + 2;
  localparam int N5W  = D2W + STR_W;
  localparam int NW   = 2 * (RAD_W + STR_W);
  localparam int RTW  = NW / 2;
  localparam int REMW = RTW + 2;
  localparam int QW   = RTW + 1;
  localparam int TW   = WEIGHT_W + 2;
  localparam int N2W  = 2 * WEIGHT_W;
  localparam int C2W  = N2W + 2;

  // configuration registers
  logic [RAD_W-1:0]   radius_r;
  logic [STR_W-1:0]   strength_r;
  logic [LAYER_W-1:0] layer_r;
  logic               erase_r;
  logic [SQW-1:0]     rsq_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= RADIUS_RST;
      strength_r <= STRENGTH_RST;
      layer_r    <= LAYER_0;
      erase_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_RADIUS:   radius_r   <= cfg_data[RAD_W-1:0];
        CFG_STRENGTH: strength_r <= cfg_data[STR_W-1:0];
        CFG_LAYER:    layer_r    <= cfg_data[LAYER_W-1:0];
        CFG_ERASE:    erase_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rsq_r <= SQW'(radius_r) * SQW'(radius_r);
  end

  // front end: differences, magnitudes, squares, distance
  logic [CW-1:0] cv [3];
  logic [CW-1:0] cc [3];

  assign cv[0] = CW'($unsigned(in_data.vertex_x));
  assign cv[1] = CW'($unsigned(in_data.vertex_y));
  assign cv[2] = CW'($unsigned(in_data.vertex_z));
  assign cc[0] = CW'($unsigned(in_data.centre_x));
  assign cc[1] = CW'($unsigned(in_data.centre_y));
  assign cc[2] = CW'($unsigned(in_data.centre_z));

  logic signed [CW:0] s1_d_r [3];
  logic [CW-1:0]      s2_a_r [3];
  logic [SQW-1:0]     s3_sq_r [3];
  logic [D2W-1:0]     s4_d2_r;
  logic [N5W-1:0]     s5_n_r;
  logic [NW-1:0]      s6_n_r;
  logic               s3_in_r, s4_in_r, s5_in_r, s6_in_r;
  logic [PRE_STEPS-1:0] pre_v_r;
  pay_t               pre_p_r [PRE_STEPS];

  logic [AW-1:0] ax [3];
  logic          far;

  always_comb begin
    far = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ax[i] = AW'(s2_a_r[i]);
      if (ax[i] > AW'(radius_r)) far = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= '0;
    end else begin
      pre_v_r <= {pre_v_r[PRE_STEPS-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    pre_p_r[0] <= '{w0: in_data.weight_in_0, w1: in_data.weight_in_1,
                    w2: in_data.weight_in_2};
    for (int k = 1; k < PRE_STEPS; k++) pre_p_r[k] <= pre_p_r[k-1];
    for (int i = 0; i < 3; i++) begin
      s1_d_r[i]  <= $signed({cv[i][CW-1], cv[i]}) - $signed({cc[i][CW-1], cc[i]});
      s2_a_r[i]  <= s1_d_r[i][CW] ? CW'(-s1_d_r[i]) : CW'(s1_d_r[i]);
      s3_sq_r[i] <= SQW'(ax[i][RAD_W-1:0]) * SQW'(ax[i][RAD_W-1:0]);
    end
    s3_in_r <= !far;
    s4_d2_r <= D2W'(s3_sq_r[0]) + D2W'(s3_sq_r[1]) + D2W'(s3_sq_r[2]);
    s4_in_r <= s3_in_r;
    s5_in_r <= s4_in_r && (s4_d2_r <= D2W'(rsq_r));
    s5_n_r  <= N5W'(s4_d2_r) * N5W'(strength_r);
    s6_in_r <= s5_in_r;
    s6_n_r  <= s5_in_r ? NW'(s5_n_r) * NW'(strength_r) : '0;
  end

  // square root, one result bit per stage
  logic [REMW-1:0] sq_rem_r  [SQ_STEPS];
  logic [RTW-1:0]  sq_root_r [SQ_STEPS];
  logic [NW-1:0]   sq_n_r    [SQ_STEPS];
  logic            sq_in_r   [SQ_STEPS];
  pay_t            sq_p_r    [SQ_STEPS];
  logic [SQ_STEPS-1:0] sq_v_r;

  logic [REMW-1:0] sq_cur   [SQ_STEPS];
  logic [REMW-1:0] sq_trial [SQ_STEPS];
  logic [RTW-1:0]  sq_rin   [SQ_STEPS];
  logic [NW-1:0]   sq_nin   [SQ_STEPS];

  always_comb begin
    for (int j = 0; j < SQ_STEPS; j++) begin
      if (j == 0) begin
        sq_cur[j] = REMW'(s6_n_r[NW-1 -: 2]);
        sq_rin[j] = '0;
        sq_nin[j] = s6_n_r;
      end else begin
        sq_cur[j] = {sq_rem_r[j-1][REMW-3:0], sq_n_r[j-1][NW-1 -: 2]};
        sq_rin[j] = sq_root_r[j-1];
        sq_nin[j] = sq_n_r[j-1];
      end
      sq_trial[j] = {sq_rin[j], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= '0;
    end else begin
      sq_v_r <= {sq_v_r[SQ_STEPS-2:0], pre_v_r[PRE_STEPS-1]};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SQ_STEPS; j++) begin
      if (sq_cur[j] >= sq_trial[j]) begin
        sq_rem_r[j]  <= sq_cur[j] - sq_trial[j];
        sq_root_r[j] <= {sq_rin[j][RTW-2:0], 1'b1};
      end else begin
        sq_rem_r[j]  <= sq_cur[j];
        sq_root_r[j] <= {sq_rin[j][RTW-2:0], 1'b0};
      end
      sq_n_r[j] <= sq_nin[j] << 2;
      sq_in_r[j] <= (j == 0) ? s6_in_r : sq_in_r[j-1];
      sq_p_r[j]  <= (j == 0) ? pre_p_r[PRE_STEPS-1] : sq_p_r[j-1];
    end
  end

  // ceiling of root over radius: numerator root_ceil + radius - 1
  logic [QW-1:0] c_num_r;
  logic          c_zr_r, c_in_r, c_v_r;
  pay_t          c_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= sq_v_r[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    c_num_r <= QW'(sq_root_r[SQ_STEPS-1]) + QW'(radius_r)
               - QW'(sq_rem_r[SQ_STEPS-1] == '0);
    c_zr_r  <= (radius_r == '0);
    c_in_r  <= sq_in_r[SQ_STEPS-1];
    c_p_r   <= sq_p_r[SQ_STEPS-1];
  end

  // distance quotient, one bit per stage
  logic [QW-1:0]    dv_num_r [DIV_STEPS];
  logic [STR_W-1:0] dv_m_r   [DIV_STEPS];
  logic             dv_zr_r  [DIV_STEPS];
  logic             dv_in_r  [DIV_STEPS];
  pay_t             dv_p_r   [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_v_r;

  logic [QW-1:0]    dv_nin [DIV_STEPS];
  logic [STR_W-1:0] dv_min [DIV_STEPS];
  logic [QW-1:0]    dv_den [DIV_STEPS];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_nin[k] = (k == 0) ? c_num_r : dv_num_r[k-1];
      dv_min[k] = (k == 0) ? '0 : dv_m_r[k-1];
      dv_den[k] = QW'(radius_r) << (DIV_STEPS - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r <= '0;
    end else begin
      dv_v_r <= {dv_v_r[DIV_STEPS-2:0], c_v_r};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (dv_nin[k] >= dv_den[k]) begin
        dv_num_r[k] <= dv_nin[k] - dv_den[k];
        dv_m_r[k]   <= dv_min[k] | (STR_W'(1) << (DIV_STEPS - 1 - k));
      end else begin
        dv_num_r[k] <= dv_nin[k];
        dv_m_r[k]   <= dv_min[k];
      end
      dv_zr_r[k] <= (k == 0) ? c_zr_r : dv_zr_r[k-1];
      dv_in_r[k] <= (k == 0) ? c_in_r : dv_in_r[k-1];
      dv_p_r[k]  <= (k == 0) ? c_p_r  : dv_p_r[k-1];
    end
  end

  // blend amount and implied alpha
  logic [STR_W-1:0]    b1_blend_r;
  logic [WEIGHT_W-1:0] b1_alpha_r;
  logic                b1_in_r, b1_v_r;
  pay_t                b1_p_r;
  logic [TW-1:0]       wsum;
  pay_t                lp;

  assign lp   = dv_p_r[DIV_STEPS-1];
  assign wsum = TW'(lp.w0) + TW'(lp.w1) + TW'(lp.w2);

  always_ff @(posedge clk) begin
    b1_blend_r <= strength_r - (dv_zr_r[DIV_STEPS-1] ? '0 : dv_m_r[DIV_STEPS-1]);
    b1_alpha_r <= (wsum >= TW'(W_MAX)) ? '0 : WEIGHT_W'(TW'(W_MAX) - wsum);
    b1_in_r    <= dv_in_r[DIV_STEPS-1];
    b1_p_r     <= lp;
  end

  // paint target layer and form total
  function automatic logic [WEIGHT_W-1:0] paint(input logic [WEIGHT_W-1:0] x,
                                                input logic [STR_W-1:0] b,
                                                input logic er);
    logic [WEIGHT_W:0] s;
    s = (WEIGHT_W+1)'(x) + (WEIGHT_W+1)'(b);
    if (er) return (x > b) ? x - b : '0;
    return s[WEIGHT_W] ? W_MAX : s[WEIGHT_W-1:0];
  endfunction

  pay_t                b2_p_r;
  logic [TW-1:0]       b2_tot_r;
  logic                b2_in_r, b2_v_r;
  pay_t                b2_p;
  logic [WEIGHT_W-1:0] b2_alpha;

  always_comb begin
    b2_p     = b1_p_r;
    b2_alpha = b1_alpha_r;
    case (layer_r)
      LAYER_ALPHA: b2_alpha = paint(b1_alpha_r, b1_blend_r, erase_r);
      LAYER_0:     b2_p.w0  = paint(b1_p_r.w0, b1_blend_r, erase_r);
      LAYER_1:     b2_p.w1  = paint(b1_p_r.w1, b1_blend_r, erase_r);
      LAYER_2:     b2_p.w2  = paint(b1_p_r.w2, b1_blend_r, erase_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    b2_p_r   <= b1_in_r ? b2_p : b1_p_r;
    b2_tot_r <= TW'(b2_alpha) + TW'(b2_p.w0) + TW'(b2_p.w1) + TW'(b2_p.w2);
    b2_in_r  <= b1_in_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else begin
      b1_v_r <= dv_v_r[DIV_STEPS-1];
      b2_v_r <= b1_v_r;
    end
  end

  // renormalize: w * 255 / total in three lanes, one bit per stage
  logic [N2W-1:0]      rn_num_r [DIV_STEPS][3];
  logic [WEIGHT_W-1:0] rn_q_r   [DIV_STEPS][3];
  logic [TW-1:0]       rn_tot_r [DIV_STEPS];
  logic                rn_in_r  [DIV_STEPS];
  pay_t                rn_p_r   [DIV_STEPS];
  logic [DIV_STEPS-1:0] rn_v_r;

  logic [N2W-1:0]      rn_nin [DIV_STEPS][3];
  logic [WEIGHT_W-1:0] rn_qin [DIV_STEPS][3];
  logic [TW-1:0]       rn_tin [DIV_STEPS];
  logic [C2W-1:0]      rn_den [DIV_STEPS];
  logic [WEIGHT_W-1:0] b2_w   [3];

  assign b2_w[0] = b2_p_r.w0;
  assign b2_w[1] = b2_p_r.w1;
  assign b2_w[2] = b2_p_r.w2;

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      rn_tin[k] = (k == 0) ? b2_tot_r : rn_tot_r[k-1];
      rn_den[k] = C2W'(rn_tin[k]) << (DIV_STEPS - 1 - k);
      for (int i = 0; i < 3; i++) begin
        rn_nin[k][i] = (k == 0) ? N2W'({b2_w[i], WEIGHT_W'(0)}) - N2W'(b2_w[i])
                                : rn_num_r[k-1][i];
        rn_qin[k][i] = (k == 0) ? '0 : rn_q_r[k-1][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rn_v_r <= '0;
    end else begin
      rn_v_r <= {rn_v_r[DIV_STEPS-2:0], b2_v_r};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (C2W'(rn_nin[k][i]) >= rn_den[k]) begin
          rn_num_r[k][i] <= N2W'(C2W'(rn_nin[k][i]) - rn_den[k]);
          rn_q_r[k][i]   <= rn_qin[k][i] | (WEIGHT_W'(1) << (DIV_STEPS - 1 - k));
        end else begin
          rn_num_r[k][i] <= rn_nin[k][i];
          rn_q_r[k][i]   <= rn_qin[k][i];
        end
      end
      rn_tot_r[k] <= rn_tin[k];
      rn_in_r[k]  <= (k == 0) ? b2_in_r : rn_in_r[k-1];
      rn_p_r[k]   <= (k == 0) ? b2_p_r  : rn_p_r[k-1];
    end
  end

  // result
  logic zero_tot;
  logic last_in;
  pay_t last_p;

  assign zero_tot = (rn_tot_r[DIV_STEPS-1] == '0);
  assign last_in  = rn_in_r[DIV_STEPS-1];
  assign last_p   = rn_p_r[DIV_STEPS-1];

  assign out_strobe = rn_v_r[DIV_STEPS-1];

  always_comb begin
    out_data.touched = last_in;
    if (!last_in) begin
      out_data.weight_out_0 = last_p.w0;
      out_data.weight_out_1 = last_p.w1;
      out_data.weight_out_2 = last_p.w2;
    end else if (zero_tot) begin
      out_data.weight_out_0 = '0;
      out_data.weight_out_1 = '0;
      out_data.weight_out_2 = '0;
    end else begin
      out_data.weight_out_0 = rn_q_r[DIV_STEPS-1][0];
      out_data.weight_out_1 = rn_q_r[DIV_STEPS-1][1];
      out_data.weight_out_2 = rn_q_r[DIV_STEPS-1][2];
    end
  end

endmodule

### sv/tbbv_checker.sv
// port level checks for the terrain blend brush vertex unit, with bind
module tbbv_checker import tbbv_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input in_t                   in_data,
  input logic                  out_strobe,
  input out_t                  out_data
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

  // every result traces back to an earlier accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result without matching transaction");

  // untouched vertex keeps its weights
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.touched |->
      out_data.weight_out_0 == $past(in_data.weight_in_0, LATENCY) &&
      out_data.weight_out_1 == $past(in_data.weight_in_1, LATENCY) &&
      out_data.weight_out_2 == $past(in_data.weight_in_2, LATENCY))
    else $error("untouched weights changed");

  // renormalized weights never sum past full scale
  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.touched |->
      (10'(out_data.weight_out_0) + 10'(out_data.weight_out_1)
       + 10'(out_data.weight_out_2)) <= 10'(W_MAX))
    else $error("weights exceed full scale");

endmodule

bind terrain_blend_brush_vertex_unit tbbv_checker u_tbbv_checker (.*);

### sim/testbench.sv
// self-checking testbench for the terrain blend brush vertex unit
module testbench;
  import tbbv_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_strobe;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  terrain_blend_brush_vertex_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  in_t vertex_queue[$];
  out_t weight_queue[$];
  int errors = 0;
  int cycle_count = 0;
  bit sender_pause = 1'b0;
  bit no_gaps = 1'b0;

  logic [23:0] brush_radius;
  logic [7:0] brush_strength;
  logic signed [2:0] target_layer;
  logic erase_mode;

  function automatic void queue_vertex(in_t t);
    vertex_queue = {vertex_queue, t};
  endfunction

  function automatic logic [7:0] paint_weight(logic [7:0] x, logic [7:0] amount);
    int v;
    if (erase_mode) v = int'(x) - int'(amount);
    else v = int'(x) + int'(amount);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic out_t brush_vertex(in_t t);
    out_t o;
    longint unsigned d[3];
    longint unsigned d2, r, s, need, m;
    longint cs[3], vs[3];
    int w[3];
    int alpha, total, amount;
    bit hit;
    cs[0] = t.centre_x; cs[1] = t.centre_y; cs[2] = t.centre_z;
    vs[0] = t.vertex_x; vs[1] = t.vertex_y; vs[2] = t.vertex_z;
    w[0] = t.weight_in_0; w[1] = t.weight_in_1; w[2] = t.weight_in_2;
    r = brush_radius;
    s = brush_strength;
    hit = 1'b1;
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      longint df;
      df = vs[i] - cs[i];
      d[i] = df < 0 ? -df : df;
      if (d[i] > r) hit = 1'b0;
    end
    if (hit) begin
      for (int i = 0; i < 3; i++) d2 += d[i] * d[i];
      if (d2 > r * r) hit = 1'b0;
    end
    if (hit) begin
      need = d2 * s * s;
      m = 0;
      while (m < s && (m * r) * (m * r) < need) m++;
      amount = int'(s - m);
      alpha = 255 - w[0] - w[1] - w[2];
      if (alpha < 0) alpha = 0;
      if (target_layer == -1) alpha = paint_weight(alpha[7:0], amount[7:0]);
      else if (target_layer >= 0 && target_layer <= 2)
        w[target_layer] = paint_weight(w[target_layer][7:0], amount[7:0]);
      total = alpha + w[0] + w[1] + w[2];
      for (int i = 0; i < 3; i++) w[i] = total == 0 ? 0 : (w[i] * 255) / total;
    end
    o.weight_out_0 = w[0][7:0];
    o.weight_out_1 = w[1][7:0];
    o.weight_out_2 = w[2][7:0];
    o.touched = hit;
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (start && !busy) begin
      weight_queue = {weight_queue, brush_vertex(in_data)};
      void'(vertex_queue.pop_front());
    end
    if (!(start && busy)) begin
      if (rst_n && !sender_pause && vertex_queue.size() > 0 &&
          (no_gaps || $urandom_range(99) >= 23)) begin
        start <= 1'b1;
        in_data <= vertex_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (out_strobe) begin
      if (weight_queue.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        out_t e;
        e = weight_queue.pop_front();
        if (out_data.weight_out_0 !== e.weight_out_0) begin
          $error("weight_out_0 exp %0d got %0d", e.weight_out_0, out_data.weight_out_0);
          errors++;
        end
        if (out_data.weight_out_1 !== e.weight_out_1) begin
          $error("weight_out_1 exp %0d got %0d", e.weight_out_1, out_data.weight_out_1);
          errors++;
        end
        if (out_data.weight_out_2 !== e.weight_out_2) begin
          $error("weight_out_2 exp %0d got %0d", e.weight_out_2, out_data.weight_out_2);
          errors++;
        end
        if (out_data.touched !== e.touched) begin
          $error("touched exp %0d got %0d", e.touched, out_data.touched);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < 400000) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RADIUS: brush_radius = value;
      CFG_STRENGTH: brush_strength = value[7:0];
      CFG_LAYER: target_layer = value[2:0];
      CFG_ERASE: erase_mode = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (vertex_queue.size() != 0 || start || weight_queue.size() != 0) @(posedge clk);
  endtask

  function automatic in_t near_vertex(int spread);
    in_t t;
    t.centre_x = $urandom; t.centre_y = $urandom; t.centre_z = $urandom;
    t.vertex_x = t.centre_x + $urandom_range(2 * spread) - spread;
    t.vertex_y = t.centre_y + $urandom_range(2 * spread) - spread;
    t.vertex_z = t.centre_z + $urandom_range(2 * spread) - spread;
    t.weight_in_0 = 8'($urandom); t.weight_in_1 = 8'($urandom);
    t.weight_in_2 = 8'($urandom);
    if ($urandom_range(3) == 0) {t.weight_in_0, t.weight_in_1, t.weight_in_2} = '0;
    return t;
  endfunction

  initial begin
    in_t t;
    logic [23:0] radii[5];
    brush_radius = RADIUS_RST;
    brush_strength = STRENGTH_RST;
    target_layer = 3'sd0;
    erase_mode = 1'b0;
    radii = '{24'd0, 24'd1, 24'd256, 24'd5000, 24'hFFFFFF};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    t = '0;
    queue_vertex(t);
    t.weight_in_0 = 8'd255; t.weight_in_1 = 8'd255; t.weight_in_2 = 8'd255;
    queue_vertex(t);
    t.vertex_x = 32'sd256;
    queue_vertex(t);
    t.vertex_x = 32'sd257;
    queue_vertex(t);
    t = '0;
    t.centre_x = 32'sh80000000; t.vertex_x = 32'sh7FFFFFFF;
    queue_vertex(t);
    t = '0;
    t.vertex_x = 32'sd100; t.vertex_y = -32'sd100; t.vertex_z = 32'sd100;
    t.weight_in_1 = 8'd40;
    queue_vertex(t);
    t.vertex_z = 32'sd200;
    queue_vertex(t);
    drain();
    repeat (LATENCY + 4) @(posedge clk);

    for (int ph = 0; ph < 24; ph++) begin
      write_reg(CFG_RADIUS, ph < 5 ? radii[ph] :
                (ph % 3 == 0 ? 24'hFFFFFF : 24'($urandom_range(2000, 1))));
      write_reg(CFG_STRENGTH, ph % 4 == 0 ? 24'd0 :
                (ph % 4 == 1 ? 24'd255 : 24'($urandom_range(255))));
      write_reg(CFG_LAYER, ph < 8 ? 24'(ph) : 24'($urandom_range(7)));
      write_reg(CFG_ERASE, 24'(ph % 2));
      no_gaps = (ph == 10);
      for (int k = 0; k < 80; k++) begin
        int spread;
        spread = (brush_radius > 24'd60000 || $urandom_range(9) == 0) ? 120000 : int'(brush_radius) + 2;
        if ($urandom_range(9) == 0) begin
          t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 24'($urandom)};
          queue_vertex(t);
        end else begin
          queue_vertex(near_vertex(spread));
        end
        if (k == 40 && ph == 3) begin
          while (vertex_queue.size() != 0) @(posedge clk);
          sender_pause = 1'b1;
          while (weight_queue.size() != 0 || start) @(posedge clk);
          sender_pause = 1'b0;
        end
      end
      drain();
      repeat (LATENCY + 4) @(posedge clk);
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
